// ----- hdl/spherical_uv_mapping_unit_assert.svh -----
// Assertion helpers for the top-level RTL.
`ifndef SPHERICAL_UV_MAPPING_UNIT_ASSERT_SVH
`define SPHERICAL_UV_MAPPING_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SUMU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define SUMU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/sumu_pkg.sv -----
package sumu_pkg;

    // Input coordinate width and CORDIC micro-rotation count
    localparam int COORD_WIDTH      = 16;
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ITERS            = (ANGLE_ITERATIONS > 32) ? 32 : ANGLE_ITERATIONS;

    // Datapath widths
    localparam int DATA_W  = 64;
    localparam int ANG_W   = 32;
    localparam int IDX_W   = 5;
    localparam int U_W     = 16;
    localparam int V_W     = 17;
    localparam int PROD_W  = COORD_WIDTH + 32;
    localparam int VNUM_W  = 34;

    // Coordinates are lifted into the 64-bit datapath by this shift
    localparam int GUARD_SHIFT = 58 - COORD_WIDTH;
    localparam int ZK_LSH      = (GUARD_SHIFT >= 30) ? GUARD_SHIFT - 30 : 0;
    localparam int ZK_RSH      = (GUARD_SHIFT < 30) ? 30 - GUARD_SHIFT : 0;

    // CORDIC gain limit in Q30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

    localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ANG_W-1:0] U_ROUND   = 32'h0000_8000;
    localparam logic [V_W-1:0]   V_ONE     = 17'd65536;

    localparam logic signed [VNUM_W-1:0] V_QUARTER = 34'sd1073741824;
    localparam logic signed [VNUM_W-1:0] V_BIAS    = 34'sd16384;
    localparam logic signed [VNUM_W-1:0] V_MAX     = 34'sd65536;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [ANG_W-1:0]         t_ang;

    // Vector state moved between cells
    typedef struct packed {
        t_data x;
        t_data y;
        t_ang  ang;
    } t_vec;

    // Side data that rides along with each point
    typedef struct packed {
        t_data zk;
        t_ang  a1;
        logic  axis;
        logic  zneg;
    } t_side;

    // atan(2^-i) in turns, 2^32 per turn
    function automatic t_ang atan_turns(input logic [IDX_W-1:0] idx);
        t_ang res;
        case (idx)
            5'd0:    res = 32'h20000000;
            5'd1:    res = 32'h12E4051E;
            5'd2:    res = 32'h09FB385B;
            5'd3:    res = 32'h051111D4;
            5'd4:    res = 32'h028B0D43;
            5'd5:    res = 32'h0145D7E1;
            5'd6:    res = 32'h00A2F61E;
            5'd7:    res = 32'h00517C55;
            5'd8:    res = 32'h0028BE53;
            5'd9:    res = 32'h00145F2F;
            5'd10:   res = 32'h000A2F98;
            5'd11:   res = 32'h000517CC;
            5'd12:   res = 32'h00028BE6;
            5'd13:   res = 32'h000145F3;
            5'd14:   res = 32'h0000A2FA;
            5'd15:   res = 32'h0000517D;
            5'd16:   res = 32'h000028BE;
            5'd17:   res = 32'h0000145F;
            5'd18:   res = 32'h00000A30;
            5'd19:   res = 32'h00000518;
            5'd20:   res = 32'h0000028C;
            5'd21:   res = 32'h00000146;
            5'd22:   res = 32'h000000A3;
            5'd23:   res = 32'h00000051;
            5'd24:   res = 32'h00000029;
            5'd25:   res = 32'h00000014;
            5'd26:   res = 32'h0000000A;
            5'd27:   res = 32'h00000005;
            5'd28:   res = 32'h00000003;
            5'd29:   res = 32'h00000001;
            5'd30:   res = 32'h00000001;
            default: res = 32'h00000000;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/sumu_in_if.sv -----
// Point channel: x, y, z coordinates
interface sumu_in_if import sumu_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                    output ready);
endinterface

// ----- hdl/sumu_out_if.sv -----
// Texture coordinate channel: u, v
interface sumu_out_if import sumu_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [U_W-1:0] u_coord;
    logic [V_W-1:0] v_coord;

    modport source (output valid, output u_coord, output v_coord, input ready);
    modport sink   (input valid, input u_coord, input v_coord, output ready);
endinterface

// ----- hdl/sumu_prep.sv -----
// Entry stage: lift coordinates, fold left half plane, scale z by the gain
module sumu_prep import sumu_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic signed [COORD_WIDTH-1:0] i_z,
    output logic                          o_valid,
    output t_vec                          o_vec,
    output t_side                         o_side
);

    logic                     r_valid;
    t_vec                     r_vec;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_axis;
    logic                     r_zneg;

    t_vec                     n_vec;
    logic signed [PROD_W-1:0] n_prod;
    t_data                    w_xs;
    t_data                    w_ys;
    t_data                    w_zk;

    // Scale into the datapath; rotate by half a turn when x is negative
    always_comb begin
        w_xs = t_data'(i_x) <<< GUARD_SHIFT;
        w_ys = t_data'(i_y) <<< GUARD_SHIFT;
        if (i_x[COORD_WIDTH-1]) begin
            n_vec.x   = -w_xs;
            n_vec.y   = -w_ys;
            n_vec.ang = HALF_TURN;
        end else begin
            n_vec.x   = w_xs;
            n_vec.y   = w_ys;
            n_vec.ang = '0;
        end
        n_prod = PROD_W'(i_z) * PROD_W'(GAIN_Q30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec  <= n_vec;
            r_prod <= n_prod;
            r_axis <= (i_x == '0) && (i_y == '0);
            r_zneg <= i_z[COORD_WIDTH-1];
        end
    end

    // z * K brought to the datapath scale (floor on right shift)
    assign w_zk = (t_data'(r_prod) <<< ZK_LSH) >>> ZK_RSH;

    assign o_valid     = r_valid;
    assign o_vec       = r_vec;
    assign o_side.zk   = w_zk;
    assign o_side.a1   = '0;
    assign o_side.axis = r_axis;
    assign o_side.zneg = r_zneg;

endmodule

// ----- hdl/sumu_cordic_cell.sv -----
// One CORDIC vectoring micro-rotation, registered
module sumu_cordic_cell import sumu_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_iter,
    input  logic             i_valid,
    input  t_vec             i_vec,
    input  t_side            i_side,
    output logic             o_valid,
    output t_vec             o_vec,
    output t_side            o_side
);

    logic  r_valid;
    t_vec  r_vec;
    t_side r_side;

    t_vec  n_vec;
    t_data w_x;
    t_data w_y;
    t_data w_dx;
    t_data w_dy;
    t_ang  w_step;

    // Rotate toward y = 0; direction from the sign of y
    always_comb begin
        w_x    = i_vec.x;
        w_y    = i_vec.y;
        w_dx   = w_y >>> i_iter;
        w_dy   = w_x >>> i_iter;
        w_step = atan_turns(i_iter);
        if (!w_y[DATA_W-1]) begin
            n_vec.x   = w_x + w_dx;
            n_vec.y   = w_y - w_dy;
            n_vec.ang = i_vec.ang + w_step;
        end else begin
            n_vec.x   = w_x - w_dx;
            n_vec.y   = w_y + w_dy;
            n_vec.ang = i_vec.ang - w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

// ----- hdl/sumu_out.sv -----
// Output register: round azimuth, turn polar angle into v, clamp
module sumu_out import sumu_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_vec           i_vec,
    input  t_side          i_side,
    output logic           o_valid,
    output logic [U_W-1:0] o_u,
    output logic [V_W-1:0] o_v
);

    logic           r_valid;
    logic [U_W-1:0] r_u;
    logic [V_W-1:0] r_v;

    logic [U_W-1:0]           n_u;
    logic [V_W-1:0]           n_v;
    t_ang                     w_arnd;
    logic signed [ANG_W-1:0]  w_phi;
    logic signed [VNUM_W-1:0] w_num;
    logic signed [VNUM_W-1:0] w_vraw;

    always_comb begin
        w_arnd = i_side.a1 + U_ROUND;
        w_phi  = i_vec.ang;
        w_num  = V_QUARTER - VNUM_W'(w_phi) + V_BIAS;
        w_vraw = w_num >>> 15;
        // on the z axis the angles mean nothing
        if (i_side.axis) begin
            n_u = '0;
            n_v = i_side.zneg ? V_ONE : '0;
        end else begin
            n_u = w_arnd[ANG_W-1 -: U_W];
            if (w_vraw[VNUM_W-1]) begin
                n_v = '0;
            end else if (w_vraw > V_MAX) begin
                n_v = V_ONE;
            end else begin
                n_v = w_vraw[V_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
            r_v <= n_v;
        end
    end

    assign o_valid = r_valid;
    assign o_u     = r_u;
    assign o_v     = r_v;

endmodule

// ----- hdl/spherical_uv_mapping_unit.sv -----
// Spherical UV mapping: takes one point (x, y, z) per cycle and returns
// u = azimuth / 2pi in [0,1) as Q0.16 and v = polar angle / pi in [0,1] as Q1.16.
// Points on the z axis give u = 0 and v = 1.0 for negative z, else 0; the zero
// vector gives u = 0, v = 0. The pipeline is an entry stage, two chains of
// CORDIC vectoring cells (azimuth, then polar angle on the radius), one cell per
// micro-rotation, and an output register; the throughput is one transaction per
// cycle while the output is not stalled. The whole pipeline holds while a result
// waits at the output and the sink is not ready.
`include "spherical_uv_mapping_unit_assert.svh"

module spherical_uv_mapping_unit import sumu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sumu_in_if.sink     i_pt,
    sumu_out_if.source  o_uv
);

    logic           w_en;
    logic           w_out_valid;
    logic [U_W-1:0] w_u;
    logic [V_W-1:0] w_v;

    logic [ITERS:0] w_s1_valid;
    t_vec           w_s1_vec  [ITERS+1];
    t_side          w_s1_side [ITERS+1];
    logic [ITERS:0] w_s2_valid;
    t_vec           w_s2_vec  [ITERS+1];
    t_side          w_s2_side [ITERS+1];

    // Pipeline advances whenever the output register is free or being taken
    assign w_en       = !w_out_valid || o_uv.ready;
    assign i_pt.ready = w_en;

    sumu_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pt.valid),
        .i_x     (i_pt.x_coord),
        .i_y     (i_pt.y_coord),
        .i_z     (i_pt.z_coord),
        .o_valid (w_s1_valid[0]),
        .o_vec   (w_s1_vec[0]),
        .o_side  (w_s1_side[0])
    );

    // Azimuth chain: vector (x, y)
    for (genvar g = 0; g < ITERS; g++) begin : g_s1
        sumu_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_iter  (IDX_W'(g)),
            .i_valid (w_s1_valid[g]),
            .i_vec   (w_s1_vec[g]),
            .i_side  (w_s1_side[g]),
            .o_valid (w_s1_valid[g+1]),
            .o_vec   (w_s1_vec[g+1]),
            .o_side  (w_s1_side[g+1])
        );
    end

    // Hand over: radius and scaled z start the polar chain, azimuth rides along
    assign w_s2_valid[0]     = w_s1_valid[ITERS];
    assign w_s2_vec[0].x     = w_s1_vec[ITERS].x;
    assign w_s2_vec[0].y     = w_s1_side[ITERS].zk;
    assign w_s2_vec[0].ang   = '0;
    assign w_s2_side[0].zk   = w_s1_side[ITERS].zk;
    assign w_s2_side[0].a1   = w_s1_vec[ITERS].ang;
    assign w_s2_side[0].axis = w_s1_side[ITERS].axis;
    assign w_s2_side[0].zneg = w_s1_side[ITERS].zneg;

    // Polar chain: vector (r, z * K)
    for (genvar g = 0; g < ITERS; g++) begin : g_s2
        sumu_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_iter  (IDX_W'(g)),
            .i_valid (w_s2_valid[g]),
            .i_vec   (w_s2_vec[g]),
            .i_side  (w_s2_side[g]),
            .o_valid (w_s2_valid[g+1]),
            .o_vec   (w_s2_vec[g+1]),
            .o_side  (w_s2_side[g+1])
        );
    end

    sumu_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s2_valid[ITERS]),
        .i_vec   (w_s2_vec[ITERS]),
        .i_side  (w_s2_side[ITERS]),
        .o_valid (w_out_valid),
        .o_u     (w_u),
        .o_v     (w_v)
    );

    assign o_uv.valid   = w_out_valid;
    assign o_uv.u_coord = w_u;
    assign o_uv.v_coord = w_v;

    // Accepted transaction lands in the entry stage
    `SUMU_ASSERT_NEXT(a_in_to_prep, i_clk, i_rst_n, i_pt.valid && i_pt.ready, w_s1_valid[0])
    // A stalled pipeline keeps its occupancy
    `SUMU_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(w_s1_valid) && $stable(w_s2_valid))
    // Last polar cell moves into the output register when enabled
    `SUMU_ASSERT_NEXT(a_last_to_out, i_clk, i_rst_n, w_en && w_s2_valid[ITERS], w_out_valid)
    // Off the z axis the azimuth chain ends with a positive radius
    `SUMU_ASSERT_IMPL(a_radius_pos, i_clk, i_rst_n, w_s1_valid[ITERS] && !w_s1_side[ITERS].axis, w_s1_vec[ITERS].x > 0)

endmodule

// ----- test/spherical_uv_mapping_unit_test.sv -----
`timescale 1ns / 100ps

module spherical_uv_mapping_unit_test;
    import sumu_pkg::*;

    // Coordinates are lifted by this shift into the 64-bit rotation datapath
    localparam int LIFT   = 58 - COORD_WIDTH;
    localparam int Z_UP   = (LIFT >= 30) ? LIFT - 30 : 0;
    localparam int Z_DOWN = (LIFT < 30) ? 30 - LIFT : 0;

    localparam logic signed [63:0] K_GAIN_Q30  = 64'sd1768195363;
    localparam logic signed [63:0] QUARTER_PHI = 64'sd1073741824;
    localparam logic signed [63:0] PHI_ROUND   = 64'sd16384;
    localparam logic signed [63:0] V_CEIL      = 64'sd65536;
    localparam logic [V_W-1:0]     V_FULL      = 17'd65536;
    localparam logic [31:0]        HALF_SPIN   = 32'h8000_0000;
    localparam logic [31:0]        U_HALF_LSB  = 32'h0000_8000;

    localparam int RANDOM_POINTS = 450;
    localparam int DRAIN_CYCLES  = 2 * ITERS + 10;
    localparam int CYCLE_LIMIT   = 200000;

    // atan(2^-i) in turns, 2^32 per turn; entry i sits at [31 - i]
    localparam logic [31:0][31:0] TURN_STEP = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
    } t_point;

    typedef struct packed {
        logic [U_W-1:0] u;
        logic [V_W-1:0] v;
    } t_uv;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] y;
        logic [31:0] ang;
    } t_sweep;

    typedef enum logic [1:0] {RX_OPEN, RX_ALTERNATE, RX_BUSY, RX_CHOKED} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sumu_in_if  pt_if ();
    sumu_out_if uv_if ();

    spherical_uv_mapping_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .o_uv    (uv_if.source)
    );

    t_point   pending_points[$];
    t_uv      expected_uv[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left  = 1;
    int       gap_left    = 0;
    t_rx_mode rx_mode     = RX_OPEN;
    int       rx_mode_left = 0;
    int       result_count = 0;
    int       total_points = 0;

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Vectoring sweep: drives y toward zero, accumulating the angle in turns
    function automatic t_sweep vector_sweep(input logic signed [63:0] x0,
                                            input logic signed [63:0] y0,
                                            input logic [31:0] a0);
        logic signed [63:0] vx, vy, dx, dy;
        logic [31:0] acc;
        t_sweep res;
        vx  = x0;
        vy  = y0;
        acc = a0;
        for (int i = 0; i < ITERS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (!vy[63]) begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + TURN_STEP[31 - i];
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - TURN_STEP[31 - i];
            end
        end
        res.x   = vx;
        res.y   = vy;
        res.ang = acc;
        return res;
    endfunction

    // Expected (u, v) for one point
    function automatic t_uv map_point(input t_point p);
        logic signed [COORD_WIDTH-1:0] cx, cy, cz;
        logic signed [63:0] ax, ay, radius, zk, prod, phi_w, vq;
        logic signed [31:0] phi;
        logic [31:0] azimuth, rounded;
        t_sweep s;
        t_uv res;
        cx = p.x;
        cy = p.y;
        cz = p.z;
        // On the z axis the azimuth is undefined: pole or origin
        if (cx == 0 && cy == 0) begin
            res.u = '0;
            res.v = (cz < 0) ? V_FULL : '0;
            return res;
        end
        ax = cx;
        ay = cy;
        ax = ax <<< LIFT;
        ay = ay <<< LIFT;
        azimuth = '0;
        // Left half plane: pre-rotate by half a turn
        if (ax < 0) begin
            ax = -ax;
            ay = -ay;
            azimuth = HALF_SPIN;
        end
        s = vector_sweep(ax, ay, azimuth);
        rounded = s.ang + U_HALF_LSB;
        res.u = rounded[31:16];

        // Polar angle from (gain * radius, gain * z)
        radius = s.x;
        prod = cz;
        prod = prod * K_GAIN_Q30;
        zk = (LIFT >= 30) ? (prod <<< Z_UP) : (prod >>> Z_DOWN);
        s = vector_sweep(radius, zk, '0);
        phi   = s.ang;
        phi_w = phi;
        vq = (QUARTER_PHI - phi_w + PHI_ROUND) >>> 15;
        if (vq < 0)
            vq = 0;
        else if (vq > V_CEIL)
            vq = V_CEIL;
        res.v = vq[V_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    task automatic add_point(input int x, input int y, input int z);
        t_point p;
        p.x = x[COORD_WIDTH-1:0];
        p.y = y[COORD_WIDTH-1:0];
        p.z = z[COORD_WIDTH-1:0];
        pending_points.push_back(p);
    endtask

    function automatic int pick_edge();
        int sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0:       return -(1 << (COORD_WIDTH - 1));
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return (1 << (COORD_WIDTH - 1)) - 1;
        endcase
    endfunction

    // Driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        t_point p;
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else if (!pt_if.valid || pt_if.ready) begin
            // Transaction accepted at this edge: predict its result
            if (pt_if.valid) begin
                p.x = pt_if.x_coord;
                p.y = pt_if.y_coord;
                p.z = pt_if.z_coord;
                expected_uv.push_back(map_point(p));
            end
            if (gap_left > 0) begin
                pt_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_points.size() > 0) begin
                p = pending_points.pop_front();
                pt_if.valid   <= 1'b1;
                pt_if.x_coord <= p.x;
                pt_if.y_coord <= p.y;
                pt_if.z_coord <= p.z;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                pt_if.valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure: a pattern picked at random from four modes, re-picked when its countdown runs out
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(20, 100);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:      uv_if.ready <= 1'b1;
            RX_ALTERNATE: uv_if.ready <= ~uv_if.ready;
            RX_BUSY:      uv_if.ready <= ($urandom_range(0, 9) < 7);
            default:      uv_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_uv want;
        if (i_rst_n && uv_if.valid && uv_if.ready) begin
            result_count++;
            if (expected_uv.size() == 0) begin
                report_mismatch($sformatf("unexpected result u=%0d v=%0d",
                                          uv_if.u_coord, uv_if.v_coord));
            end else begin
                want = expected_uv.pop_front();
                if (uv_if.u_coord !== want.u)
                    report_mismatch($sformatf("u_coord got %0d want %0d",
                                              uv_if.u_coord, want.u));
                if (uv_if.v_coord !== want.v)
                    report_mismatch($sformatf("v_coord got %0d want %0d",
                                              uv_if.v_coord, want.v));
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int sel, x, y, z;
        int lo, hi;
        lo = -(1 << (COORD_WIDTH - 1));
        hi = (1 << (COORD_WIDTH - 1)) - 1;
        pt_if.valid   = 1'b0;
        pt_if.x_coord = '0;
        pt_if.y_coord = '0;
        pt_if.z_coord = '0;
        uv_if.ready   = 1'b1;

        // Origin and the poles
        add_point(0, 0, 0);
        add_point(0, 0, hi);
        add_point(0, 0, lo);
        add_point(0, 0, 1);
        add_point(0, 0, -1);
        // Axes in the xy plane, including the half-turn pre-rotation
        add_point(hi, 0, 0);
        add_point(lo, 0, 0);
        add_point(0, hi, 0);
        add_point(0, lo, 0);
        add_point(1, 0, 0);
        add_point(-1, 0, 0);
        add_point(0, 1, -1);
        add_point(0, -1, 1);
        // Corners of the coordinate cube
        add_point(hi, hi, hi);
        add_point(lo, lo, lo);
        add_point(hi, lo, hi);
        add_point(lo, hi, lo);
        add_point(hi, lo, lo);
        add_point(lo, hi, hi);
        // Azimuth just below a full turn rounds back to zero, plus other off-axis points
        add_point(hi, -1, 0);
        add_point(hi, -1, lo);
        add_point(lo, -1, 5);
        add_point(-1, -1, 1);
        add_point(1, 1, lo);

        // Random points: full range, small, on axis, near the wrap, extremes
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 5) begin
                x = $urandom();
                y = $urandom();
                z = $urandom();
            end else if (sel < 7) begin
                x = $urandom_range(0, 16) - 8;
                y = $urandom_range(0, 16) - 8;
                z = $urandom_range(0, 16) - 8;
            end else if (sel == 7) begin
                x = ($urandom_range(0, 1) == 1) ? 0 : pick_edge();
                y = 0;
                z = $urandom();
            end else if (sel == 8) begin
                x = $urandom();
                y = $urandom_range(0, 6) - 3;
                z = $urandom();
            end else begin
                x = pick_edge();
                y = pick_edge();
                z = pick_edge();
            end
            add_point(x, y, z);
        end
        total_points = pending_points.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every point has to come back; then watch for strays
        wait (result_count >= total_points);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
